FILE: sv/fftc_pkg.sv
// Package for the five-tuple flow counter table: key and entry layouts,
// command and status codes, default table geometry. No dependencies.
package fftc_pkg;

	localparam int FFTC_BUCKETS = 256;
	localparam int FFTC_WAYS    = 4;

	// Command codes carried in the low bits of the input tuser.
	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Result status codes.
	localparam logic [2:0] STAT_HIT     = 3'd0;
	localparam logic [2:0] STAT_INSERT  = 3'd1;
	localparam logic [2:0] STAT_DROP    = 3'd2;
	localparam logic [2:0] STAT_READ    = 3'd3;
	localparam logic [2:0] STAT_CLEARED = 3'd4;

	// Normalized flow key: IPv4 keys carry zero upper address bits.
	typedef struct packed {
		logic        ipv6;
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [31:0] ports;   // source port high, destination port low
		logic [7:0]  proto;
	} key_t;

	typedef struct packed {
		key_t        key;
		logic [31:0] packets;
		logic [63:0] bytes;
	} entry_t;

	// Memory access controls from the sequencer to the table memories.
	typedef struct packed {
		logic rd_en;
		logic used_we;
		logic row_we;
	} mem_ctl_t;

endpackage

FILE: sv/fftc_hash.sv
// Bucket hash for the flow table: XOR-shift hash of the key followed by a
// reduction modulo the bucket count through a reciprocal multiply. Uses fftc_pkg.
module fftc_hash import fftc_pkg::*; #(
	parameter int BUCKETS = FFTC_BUCKETS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  key_t                       key,
	output logic                       bkt_valid,
	output logic [$clog2(BUCKETS)-1:0] bkt
);

	localparam int BW = $clog2(BUCKETS);
	localparam int K  = 32 + BW;
	// floor(2^K / BUCKETS) fits in 33 bits; the quotient it gives is low by at most one.
	localparam logic [63:0] RECIP = (64'd1 << K) / 64'(BUCKETS);

	logic [23:0] mix;
	logic [31:0] t, hv4, hv6, h0, h;
	logic [31:0] sw, dw;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [31:0] h_s1, h_s2, q_s2;
	logic [32:0] r_s3;
	logic [BW-1:0] bkt_s4;
	logic [64:0] prod;
	logic [48:0] qb;

	always_comb begin
		mix = {key.ports[31:16], 8'd0} ^ {8'd0, key.ports[15:0]} ^ {16'd0, key.proto};
		t   = {8'd0, mix} >> 5;
		sw  = key.src_hi[63:32] ^ key.src_hi[31:0] ^ key.src_lo[63:32] ^ key.src_lo[31:0];
		dw  = key.dst_hi[63:32] ^ key.dst_hi[31:0] ^ key.dst_lo[63:32] ^ key.dst_lo[31:0];
		hv4 = key.src_lo[31:0] ^ (key.dst_lo[31:0] << 13) ^ t;
		hv6 = t ^ sw ^ (dw << 7);
		h0  = key.ipv6 ? hv6 : hv4;
		h   = h0 ^ (h0 >> 16);
		prod = 65'(h_s1) * 65'(RECIP[32:0]);
		qb   = 49'(q_s2) * 49'(BUCKETS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		h_s1 <= h;
		h_s2 <= h_s1;
		q_s2 <= 32'(prod >> K);
		r_s3 <= 33'(49'(h_s2) - qb);
		if (r_s3 >= 33'(BUCKETS)) begin
			bkt_s4 <= BW'(r_s3 - 33'(BUCKETS));
		end else begin
			bkt_s4 <= BW'(r_s3);
		end
	end

	assign bkt_valid = v_s4;
	assign bkt       = bkt_s4;

endmodule

FILE: sv/fftc_mem.sv
// Table storage: one row per bucket, a used-bit memory and an entry memory,
// each read synchronously through a registered output. Uses fftc_pkg.
module fftc_mem import fftc_pkg::*; #(
	parameter int BUCKETS = FFTC_BUCKETS,
	parameter int WAYS    = FFTC_WAYS
) (
	input  logic                       clk,
	input  mem_ctl_t                   ctl,
	input  logic [$clog2(BUCKETS)-1:0] rd_addr,
	input  logic [$clog2(BUCKETS)-1:0] wr_addr,
	input  logic [WAYS-1:0]            wr_used,
	input  entry_t [WAYS-1:0]          wr_row,
	output logic [WAYS-1:0]            rd_used,
	output entry_t [WAYS-1:0]          rd_row
);

	logic [WAYS-1:0]   used_mem [BUCKETS];
	entry_t [WAYS-1:0] row_mem  [BUCKETS];

	always_ff @(posedge clk) begin
		if (ctl.used_we) begin
			used_mem[wr_addr] <= wr_used;
		end
		if (ctl.rd_en) begin
			rd_used <= used_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.row_we) begin
			row_mem[wr_addr] <= wr_row;
		end
		if (ctl.rd_en) begin
			rd_row <= row_mem[rd_addr];
		end
	end

endmodule

FILE: sv/five_tuple_flow_counter_table_unit.sv
// Five-tuple flow counter table. Add: four hash and modulo stages, the first at the accepting
// edge, one bucket read, then the compare and write-back that loads the output register once
// it is free; read: slot index split, bucket read, output register; clear: a sweep of all
// buckets. One request is in work at a time, so a new request is taken only once the last
// is through. The output register holds a result while the next request is taken. After
// reset the used bits are swept to zero, one bucket a cycle, with no request accepted.
module five_tuple_flow_counter_table_unit import fftc_pkg::*; #(
	parameter int BUCKETS = FFTC_BUCKETS,
	parameter int WAYS    = FFTC_WAYS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo, src_port, dst_port,
	// ip_proto, pkt_len, entry_index, zero fill
	input  logic [327:0] s_axis_tdata,
	// cmd, is_ipv6
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// flow_src_hi, flow_src_lo, flow_dst_hi, flow_dst_lo, flow_src_port,
	// flow_dst_port, flow_proto, flow_packets, flow_bytes
	output logic [391:0] m_axis_tdata,
	// status, slot_valid, flow_is_ipv6
	output logic [4:0]   m_axis_tuser
);

	localparam int BW = $clog2(BUCKETS);
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	// Ceiling reciprocal of WAYS with 16 fraction bits: exact for 10-bit indexes.
	localparam int RI = ((1 << 16) + WAYS - 1) / WAYS;

	// Sequencer states.
	localparam logic [2:0] ST_CLR  = 3'd0;  // sweeping used bits to zero
	localparam logic [2:0] ST_IDLE = 3'd1;  // waiting for a request
	localparam logic [2:0] ST_HASH = 3'd2;  // add: bucket hash in flight
	localparam logic [2:0] ST_DIV  = 3'd3;  // read: split the slot index
	localparam logic [2:0] ST_RD   = 3'd4;  // bucket row is on the read port

	logic [2:0]    state_q;
	logic [BW-1:0] clr_addr_q;
	logic          clr_report_q;
	logic          is_add_q;
	key_t          key_q;
	logic [15:0]   len_q;
	logic [9:0]    idx_q;
	logic [9:0]    quo_q;
	logic [WW-1:0] way_q;
	logic          rd_ok_q;
	logic [BW-1:0] bkt_q;

	logic          m_valid_q;
	logic [391:0]  m_data_q;
	logic [4:0]    m_user_q;

	logic          accept;
	logic [1:0]    in_cmd;
	key_t          in_key;
	logic [26:0]   idx_prod;
	logic          hv;
	logic [BW-1:0] hbkt;
	logic          out_free;

	mem_ctl_t          mctl;
	logic [BW-1:0]     rd_addr, wr_addr;
	logic [WAYS-1:0]   wr_used, rd_used;
	entry_t [WAYS-1:0] wr_row, rd_row;

	logic [WAYS-1:0] hit_vec;
	logic            hit, have_free;
	logic [WW-1:0]   hit_way, free_way, tgt_way;
	logic [13:0]     way_full;
	entry_t          upd, res_entry;
	logic            res_valid;
	logic [2:0]      res_status;
	logic            out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_cmd        = s_axis_tuser[1:0];
	assign out_free      = !m_valid_q || m_axis_tready;

	// IPv4 keys drop the upper address bits so that keys compare as whole fields.
	always_comb begin
		in_key.ipv6   = s_axis_tuser[2];
		in_key.src_hi = s_axis_tuser[2] ? s_axis_tdata[63:0] : 64'd0;
		in_key.src_lo = s_axis_tuser[2] ? s_axis_tdata[127:64] : {32'd0, s_axis_tdata[95:64]};
		in_key.dst_hi = s_axis_tuser[2] ? s_axis_tdata[191:128] : 64'd0;
		in_key.dst_lo = s_axis_tuser[2] ? s_axis_tdata[255:192] :
			{32'd0, s_axis_tdata[223:192]};
		in_key.ports  = {s_axis_tdata[271:256], s_axis_tdata[287:272]};
		in_key.proto  = s_axis_tdata[295:288];
		idx_prod      = 27'(s_axis_tdata[321:312]) * 27'(RI);
	end

	fftc_hash #(.BUCKETS(BUCKETS)) u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && in_cmd == CMD_ADD),
		.key       (in_key),
		.bkt_valid (hv),
		.bkt       (hbkt)
	);

	fftc_mem #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_mem (
		.clk     (clk),
		.ctl     (mctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_used (wr_used),
		.wr_row  (wr_row),
		.rd_used (rd_used),
		.rd_row  (rd_row)
	);

	// Bucket search: a valid way with an equal key is a hit; otherwise the lowest
	// free way takes the new flow. Ways are scanned from the top so the lowest wins.
	always_comb begin
		hit_vec   = '0;
		hit_way   = '0;
		free_way  = '0;
		have_free = 1'b0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			hit_vec[w] = rd_used[w] && (rd_row[w].key == key_q);
			if (hit_vec[w]) begin
				hit_way = WW'(w);
			end
			if (!rd_used[w]) begin
				free_way  = WW'(w);
				have_free = 1'b1;
			end
		end
		hit     = |hit_vec;
		tgt_way = hit ? hit_way : free_way;

		if (hit) begin
			upd         = rd_row[hit_way];
			upd.packets = rd_row[hit_way].packets + 32'd1;
			upd.bytes   = rd_row[hit_way].bytes + 64'(len_q);
		end else begin
			upd.key     = key_q;
			upd.packets = 32'd1;
			upd.bytes   = 64'(len_q);
		end

		wr_row          = rd_row;
		wr_row[tgt_way] = upd;
		wr_used         = rd_used;
		wr_used[tgt_way] = 1'b1;
		// During a sweep the write data for the used bits is all zero.
		if (state_q == ST_CLR) begin
			wr_used = '0;
		end

		way_full = 14'(idx_q) - 14'(quo_q) * 14'(WAYS);

		if (is_add_q) begin
			res_valid  = hit || have_free;
			res_entry  = upd;
			res_status = hit ? STAT_HIT : (have_free ? STAT_INSERT : STAT_DROP);
		end else begin
			res_valid  = rd_ok_q && rd_used[way_q];
			res_entry  = rd_row[way_q];
			res_status = STAT_READ;
		end
		if (!res_valid) begin
			res_entry = '0;
		end
	end

	// Memory access: reads are issued once the bucket row is known; the only
	// write-back happens in ST_RD while no other read is outstanding, so no
	// two accesses to one row ever overlap.
	always_comb begin
		mctl     = '0;
		rd_addr  = bkt_q;
		wr_addr  = bkt_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				mctl.used_we = 1'b1;
				wr_addr      = clr_addr_q;
				out_load     = clr_report_q && (clr_addr_q == BW'(BUCKETS - 1)) && out_free;
			end
			ST_HASH: begin
				mctl.rd_en = hv;
				rd_addr    = hbkt;
			end
			ST_DIV: begin
				mctl.rd_en = 1'b1;
				rd_addr    = BW'(quo_q);
			end
			ST_RD: begin
				out_load     = out_free;
				mctl.used_we = out_free && is_add_q && (hit || have_free);
				mctl.row_we  = mctl.used_we;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_addr_q   <= '0;
			clr_report_q <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					if (clr_addr_q == BW'(BUCKETS - 1)) begin
						if (!clr_report_q || out_free) begin
							state_q      <= ST_IDLE;
							clr_report_q <= 1'b0;
						end
					end else begin
						clr_addr_q <= clr_addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						priority if (in_cmd == CMD_CLEAR) begin
							state_q      <= ST_CLR;
							clr_addr_q   <= '0;
							clr_report_q <= 1'b1;
						end else if (in_cmd == CMD_ADD) begin
							state_q <= ST_HASH;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_HASH: begin
					if (hv) begin
						state_q <= ST_RD;
					end
				end
				ST_DIV: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_add_q <= (in_cmd == CMD_ADD);
			key_q    <= in_key;
			len_q    <= s_axis_tdata[311:296];
			idx_q    <= s_axis_tdata[321:312];
			quo_q    <= idx_prod[25:16];
		end
		if (state_q == ST_HASH && hv) begin
			bkt_q <= hbkt;
		end
		if (state_q == ST_DIV) begin
			way_q   <= WW'(way_full);
			rd_ok_q <= 32'(quo_q) < 32'(BUCKETS);
		end
		if (out_load) begin
			if (state_q == ST_CLR) begin
				m_data_q <= '0;
				m_user_q <= {2'b00, STAT_CLEARED};
			end else begin
				m_data_q <= {res_entry.bytes, res_entry.packets, res_entry.key.proto,
					res_entry.key.ports[15:0], res_entry.key.ports[31:16],
					res_entry.key.dst_lo, res_entry.key.dst_hi,
					res_entry.key.src_lo, res_entry.key.src_hi};
				m_user_q <= {res_entry.key.ipv6, res_valid, res_status};
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// A stored flow key appears at most once in its bucket.
	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD && is_add_q) |-> $onehot0(hit_vec))
		else $error("flow key found in more than one way");

	// A pending result is never overwritten.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register overwritten");

	// Every bucket read is followed by the compare state.
	a_rd_next: assert property (@(posedge clk) disable iff (!arst_n)
		mctl.rd_en |=> state_q == ST_RD)
		else $error("bucket read without compare");

	// Entry rows are written only on a hit or insert, never during a sweep.
	a_row_we: assert property (@(posedge clk) disable iff (!arst_n)
		mctl.row_we |-> (state_q == ST_RD && is_add_q && mctl.used_we))
		else $error("entry row written outside write-back");

	// No request is taken while the used bits are being swept.
	a_clr_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !s_axis_tready)
		else $error("request accepted during clear");

endmodule

FILE: test/flow_table_checker.sv
// Checker for the five-tuple flow counter table: watches both streams, keeps
// its own copy of the flow table and compares every result. Depends on fftc_pkg.
module flow_table_checker import fftc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [327:0] s_axis_tdata,
	input  logic [2:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [391:0] m_axis_tdata,
	input  logic [4:0]   m_axis_tuser,
	output int           fail_count,
	output int           pending_count
);

	localparam int SLOTS = FFTC_BUCKETS * FFTC_WAYS;

	typedef struct packed {
		logic [391:0] data;
		logic [4:0]   user;
	} flow_result_t;

	logic        tbl_used [SLOTS];
	entry_t      tbl_entry [SLOTS];
	flow_result_t result_queue[$];

	function automatic logic [31:0] bucket_hash(key_t k);
		logic [31:0] s, d, h;
		s = k.ipv6 ? 32'd0 : k.src_lo[31:0];
		d = k.ipv6 ? 32'd0 : k.dst_lo[31:0];
		h = (s ^ (d << 13)) ^ ((({16'd0, k.ports[31:16]} << 8) ^ {16'd0, k.ports[15:0]}
			^ {24'd0, k.proto}) >> 5);
		if (k.ipv6) begin
			h ^= k.src_hi[63:32]; h ^= k.dst_hi[63:32] << 7;
			h ^= k.src_hi[31:0];  h ^= k.dst_hi[31:0] << 7;
			h ^= k.src_lo[63:32]; h ^= k.dst_lo[63:32] << 7;
			h ^= k.src_lo[31:0];  h ^= k.dst_lo[31:0] << 7;
		end
		h ^= h >> 16;
		return h % FFTC_BUCKETS;
	endfunction

	function automatic flow_result_t pack_entry(logic [2:0] status, entry_t e);
		flow_result_t r;
		r.data = {e.bytes, e.packets, e.key.proto, e.key.ports[15:0], e.key.ports[31:16],
			e.key.dst_lo, e.key.dst_hi, e.key.src_lo, e.key.src_hi};
		r.user = {e.key.ipv6, 1'b1, status};
		return r;
	endfunction

	// Compares one result field and reports it by name; returns the number of errors.
	function automatic int check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s expected %h actual %h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Applies one request to the table copy and returns the result it must cause.
	function automatic flow_result_t apply_request(logic [327:0] d, logic [2:0] u);
		flow_result_t r;
		key_t k;
		int base, free_slot, idx;
		r = '0;
		if (u[1:0] == CMD_CLEAR) begin
			for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
			r.user = {2'b00, STAT_CLEARED};
			return r;
		end
		if (u[1:0] != CMD_ADD) begin
			idx = d[321:312];
			r.user = {2'b00, STAT_READ};
			if (idx < SLOTS && tbl_used[idx]) r = pack_entry(STAT_READ, tbl_entry[idx]);
			return r;
		end
		k.ipv6   = u[2];
		k.src_hi = u[2] ? d[63:0] : 64'd0;
		k.src_lo = u[2] ? d[127:64] : {32'd0, d[95:64]};
		k.dst_hi = u[2] ? d[191:128] : 64'd0;
		k.dst_lo = u[2] ? d[255:192] : {32'd0, d[223:192]};
		k.ports  = {d[271:256], d[287:272]};
		k.proto  = d[295:288];
		base = bucket_hash(k) * FFTC_WAYS;
		free_slot = -1;
		for (int w = 0; w < FFTC_WAYS; w++) begin
			if (!tbl_used[base + w]) begin
				if (free_slot < 0) free_slot = base + w;
			end else if (tbl_entry[base + w].key == k) begin
				tbl_entry[base + w].packets += 1;
				tbl_entry[base + w].bytes += {48'd0, d[311:296]};
				return pack_entry(STAT_HIT, tbl_entry[base + w]);
			end
		end
		if (free_slot < 0) begin
			r.user = {2'b00, STAT_DROP};
			return r;
		end
		tbl_used[free_slot] = 1'b1;
		tbl_entry[free_slot] = {k, 32'd1, {48'd0, d[311:296]}};
		return pack_entry(STAT_INSERT, tbl_entry[free_slot]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		flow_result_t want;
		int           errs;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
			result_queue = {};
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			errs = 0;
			if (m_axis_tvalid && m_axis_tready) begin
				if (result_queue.size() == 0) begin
					$error("result with none expected: tuser %h", m_axis_tuser);
					errs = 1;
				end else begin
					want = result_queue.pop_front();
					errs += check_field("status", 64'(want.user[2:0]), 64'(m_axis_tuser[2:0]));
					errs += check_field("slot_valid", 64'(want.user[3]), 64'(m_axis_tuser[3]));
					errs += check_field("flow_is_ipv6", 64'(want.user[4]),
						64'(m_axis_tuser[4]));
					errs += check_field("flow_src_hi", want.data[63:0], m_axis_tdata[63:0]);
					errs += check_field("flow_src_lo", want.data[127:64], m_axis_tdata[127:64]);
					errs += check_field("flow_dst_hi", want.data[191:128],
						m_axis_tdata[191:128]);
					errs += check_field("flow_dst_lo", want.data[255:192],
						m_axis_tdata[255:192]);
					errs += check_field("flow_src_port", 64'(want.data[271:256]),
						64'(m_axis_tdata[271:256]));
					errs += check_field("flow_dst_port", 64'(want.data[287:272]),
						64'(m_axis_tdata[287:272]));
					errs += check_field("flow_proto", 64'(want.data[295:288]),
						64'(m_axis_tdata[295:288]));
					errs += check_field("flow_packets", 64'(want.data[327:296]),
						64'(m_axis_tdata[327:296]));
					errs += check_field("flow_bytes", want.data[391:328],
						m_axis_tdata[391:328]);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				result_queue.push_back(apply_request(s_axis_tdata, s_axis_tuser));
			fail_count <= fail_count + errs;
			pending_count <= result_queue.size();
		end
	end

endmodule

FILE: test/five_tuple_flow_counter_table_unit_tb.sv
// Testbench top for the five-tuple flow counter table: drives add, read and
// clear requests with random gaps and stalls. Depends on fftc_pkg and the checker.
module five_tuple_flow_counter_table_unit_tb import fftc_pkg::*;;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [327:0] s_axis_tdata = '0;
	logic [2:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [391:0] m_axis_tdata;
	logic [4:0]   m_axis_tuser;
	int           fail_count, pending_count;
	int           idle_cycles = 0;
	int           adds = 0, reads = 0, clears = 0;

	// Small pool of flows so that hits really happen.
	logic [327:0] flow_pool[32];

	always #4 clk = ~clk;

	five_tuple_flow_counter_table_unit u_top (.*);

	flow_table_checker u_checker (.*);

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	// Receiver side stalls at random, with a stretch of always-ready phases.
	always @(posedge clk) begin
		if (arst_n) m_axis_tready <= (($urandom_range(0, 3) != 0) || (adds % 400 < 60));
	end

	// The watchdog counts cycles with no request or result accepted.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_request(logic [2:0] user, logic [327:0] data);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= user;
		s_axis_tdata  <= data;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		case (user[1:0])
			CMD_ADD:   adds++;
			CMD_CLEAR: clears++;
			default:   reads++;
		endcase
	endtask

	task automatic pause_sender();
		int n;
		n = gap_len();
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [327:0] rand_data();
		logic [327:0] d;
		for (int i = 0; i < 11; i++) d[i*32 +: 32] = $urandom();
		d[327:322] = '0;
		return d;
	endfunction

	initial begin
		logic [327:0] d;
		int           k;
		for (int i = 0; i < 32; i++) flow_pool[i] = rand_data();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: field extremes, every command and the special cases.
		send_request({1'b0, CMD_READ}, '0);                // unused slot
		send_request({1'b1, CMD_ADD}, '0);                 // all-zero IPv6 key
		send_request({1'b1, CMD_ADD}, '0);                 // hit on it
		// IPv6 keys whose upper source words change together hash to the same
		// bucket as the all-zero key: three more fill it and the last is dropped.
		for (int j = 1; j <= 4; j++) begin
			d = '0;
			d[63:32]  = 32'(j);
			d[127:96] = 32'(j);
			send_request({1'b1, CMD_ADD}, d);
		end
		send_request({1'b0, CMD_ADD}, {6'd0, {322{1'b1}}}); // IPv4, upper bits ignored
		send_request({1'b0, CMD_ADD}, {6'd0, {322{1'b1}}});
		send_request({1'b1, CMD_ADD}, {6'd0, {322{1'b1}}});
		send_request({1'b0, 2'd3}, {6'd0, 10'd1023, 312'd0}); // command three reads
		d = rand_data();
		for (int i = 0; i < 6; i++) send_request({1'b0, CMD_ADD}, d); // same flow repeats
		// Same ports/proto, IPv4 source differing only in the ignored upper word:
		// same key, so this must hit one entry.
		d[63:0] = 64'hffff_ffff_ffff_ffff;
		send_request({1'b0, CMD_ADD}, d);
		for (int i = 0; i < 4; i++) send_request({1'b0, CMD_READ}, {6'd0, 10'(i), 312'd0});
		send_request({1'b0, CMD_CLEAR}, '0);
		send_request({1'b0, CMD_READ}, '0);
		send_request({1'b1, CMD_READ}, {6'd0, 10'd1023, 312'd0});
		pause_sender();

		// Random part: mostly adds from the flow pool so counters climb and
		// buckets fill; some fresh flows, reads of any slot, rare clears.
		for (int n = 0; n < 1530; n++) begin
			k = $urandom_range(0, 99);
			if (k < 55) begin
				d = flow_pool[$urandom_range(0, 31)];
				d[311:296] = 16'($urandom());
				send_request({d[0], CMD_ADD}, d);
			end else if (k < 75) begin
				d = rand_data();
				send_request({1'($urandom()), CMD_ADD}, d);
			end else if (k < 98) begin
				d = rand_data();
				send_request({1'($urandom()), 2'(CMD_READ + $urandom_range(0, 1) * 2)}, d);
			end else begin
				send_request({1'($urandom()), CMD_CLEAR}, rand_data());
			end
			if ((n / 150) % 2 == 1) pause_sender();
		end
		s_axis_tvalid <= 1'b0;

		while (pending_count != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Covered %0d adds, %0d reads and %0d clears with random stalls.",
			adds, reads, clears);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
